### hdl/decimal_to_q16_16_parser_top_macros.svh
// assertion macros for the decimal to q16.16 parser checker
// used by dqp_checker.sv, no other dependencies
`ifndef DECIMAL_TO_Q16_16_PARSER_TOP_MACROS_SVH
`define DECIMAL_TO_Q16_16_PARSER_TOP_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define DQP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dqp checker: assertion failed");

// clocked assertion that also holds across reset
`define DQP_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("dqp checker: reset assertion failed");

`endif

### hdl/dqp_pkg.sv
// shared types, constants and the power-of-ten table for the parser
// no dependencies
`default_nettype none

package dqp_pkg;

    localparam int unsigned DQP_MAX_FRAC_DIGITS = 9;
    localparam int unsigned DQP_INT_BITS        = 16;
    localparam int unsigned DQP_Q_BITS          = 16;
    localparam int unsigned DQP_FRAC_BITS       = 30;
    localparam int unsigned DQP_CNT_BITS        = $clog2(DQP_Q_BITS);

    typedef struct packed {
        logic char_en;
        logic div_init;
        logic div_step;
        logic load_out;
        logic clear;
    } dqp_cmd_t;

    typedef struct packed {
        logic div_last;
    } dqp_status_t;

    function automatic logic [DQP_FRAC_BITS-1:0] dqp_pow10(input logic [3:0] k);
        logic [DQP_FRAC_BITS-1:0] p;
        unique case (k)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### hdl/dqp_ctrl.sv
// controller for the parser: handshakes, divider sequencing, output register valid
// depends on dqp_pkg
`default_nettype none

module dqp_ctrl
    import dqp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_last,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire dqp_status_t status,
    output dqp_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;
    logic       load_out;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == ST_LOAD) && (!m_valid_reg || m_ready);

    always_comb begin
        cmd.char_en  = accept;
        cmd.div_init = accept && s_last;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.load_out = load_out;
        cmd.clear    = load_out;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_last) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_last) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (load_out) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        priority if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### hdl/dqp_datapath.sv
// datapath for the parser: character parsing, restoring divider, output register
// depends on dqp_pkg
`default_nettype none

module dqp_datapath
    import dqp_pkg::*;
#(
    parameter int unsigned MAX_FRAC_DIGITS = DQP_MAX_FRAC_DIGITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dqp_cmd_t    cmd,
    output dqp_status_t      status,
    input  wire logic [7:0]  s_char_code,
    output logic signed [31:0] m_value
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_INT   = 2'd1;
    localparam logic [1:0] PH_FRAC  = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_POINT = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    logic [1:0]               phase_reg, phase_next;
    logic                     neg_reg, neg_next;
    logic [DQP_INT_BITS-1:0]  int_reg, int_next;
    logic [DQP_FRAC_BITS-1:0] frac_reg, frac_next;
    logic [3:0]               fcnt_reg, fcnt_next;

    logic [DQP_FRAC_BITS-1:0] rem_reg;
    logic [DQP_Q_BITS-1:0]    quo_reg;
    logic [DQP_CNT_BITS-1:0]  cnt_reg;
    logic signed [31:0]       value_reg;

    logic                     is_digit;
    logic [3:0]               digit;
    logic [DQP_INT_BITS-1:0]  int_acc;
    logic [DQP_FRAC_BITS-1:0] frac_acc;
    logic                     frac_room;

    logic [DQP_FRAC_BITS-1:0] divisor;
    logic [DQP_FRAC_BITS:0]   rem_shift;
    logic [DQP_FRAC_BITS:0]   rem_sub;
    logic                     rem_ge;
    logic [DQP_FRAC_BITS-1:0] rem_step;
    logic [31:0]              mag;

    assign is_digit  = (s_char_code >= CH_ZERO) && (s_char_code <= CH_NINE);
    assign digit     = s_char_code[3:0];
    assign int_acc   = DQP_INT_BITS'(int_reg * DQP_INT_BITS'(10))
                       + DQP_INT_BITS'(digit);
    assign frac_acc  = DQP_FRAC_BITS'(frac_reg * DQP_FRAC_BITS'(10))
                       + DQP_FRAC_BITS'(digit);
    assign frac_room = fcnt_reg < 4'(MAX_FRAC_DIGITS);

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        fcnt_next  = fcnt_reg;
        unique case (phase_reg)
            PH_START: begin
                priority if (s_char_code == CH_MINUS) begin
                    neg_next   = 1'b1;
                    phase_next = PH_INT;
                end else if (is_digit) begin
                    int_next   = int_acc;
                    phase_next = PH_INT;
                end else if (s_char_code == CH_POINT) begin
                    phase_next = PH_FRAC;
                end else begin
                    phase_next = PH_STOP;
                end
            end
            PH_INT: begin
                priority if (is_digit) begin
                    int_next   = int_acc;
                end else if (s_char_code == CH_POINT) begin
                    phase_next = PH_FRAC;
                end else begin
                    phase_next = PH_STOP;
                end
            end
            PH_FRAC: begin
                if (is_digit) begin
                    if (frac_room) begin
                        frac_next = frac_acc;
                        fcnt_next = fcnt_reg + 4'd1;
                    end
                end else begin
                    phase_next = PH_STOP;
                end
            end
            default: begin
            end
        endcase
    end

    // one quotient bit per step, remainder always below the divisor
    assign divisor   = dqp_pow10(fcnt_reg);
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_sub   = rem_shift - {1'b0, divisor};
    assign rem_ge    = rem_shift >= {1'b0, divisor};
    assign rem_step  = rem_ge ? rem_sub[DQP_FRAC_BITS-1:0] : rem_shift[DQP_FRAC_BITS-1:0];

    assign status.div_last = (cnt_reg == DQP_CNT_BITS'(DQP_Q_BITS - 1));

    assign mag     = {int_reg, quo_reg};
    assign m_value = value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            fcnt_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            if (cmd.clear) begin
                phase_reg <= PH_START;
                neg_reg   <= 1'b0;
                int_reg   <= '0;
                frac_reg  <= '0;
                fcnt_reg  <= '0;
            end else if (cmd.char_en) begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                int_reg   <= int_next;
                frac_reg  <= frac_next;
                fcnt_reg  <= fcnt_next;
            end
            if (cmd.div_init) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + DQP_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= frac_next;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[DQP_Q_BITS-2:0], rem_ge};
        end
        if (cmd.load_out) begin
            value_reg <= signed'(neg_reg ? (32'd0 - mag) : mag);
        end
    end

endmodule

`default_nettype wire

### hdl/decimal_to_q16_16_parser_top.sv
// Decimal literal to Q16.16 parser. Each accepted input word is one ASCII character of
// a literal (optional minus, integer digits, one point, fraction digits). The word marked
// last then starts a 16-step restoring divide of the fraction by its power of ten, one
// quotient bit per cycle, followed by a load of the output register. s_ready therefore
// stays low from the last character until that load, and longer while the load waits
// because the previous result word still waits in the output register. The
// result word waits in its output register while the next literal streams in.
// Depends on dqp_pkg, dqp_ctrl and dqp_datapath.
`default_nettype none

module decimal_to_q16_16_parser_top
    import dqp_pkg::*;
#(
    parameter int unsigned MAX_FRAC_DIGITS = DQP_MAX_FRAC_DIGITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_char_code,
    input  wire logic              s_last,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [31:0]     m_value
);

    dqp_cmd_t    cmd;
    dqp_status_t status;

    dqp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dqp_datapath #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_char_code (s_char_code),
        .m_value     (m_value)
    );

endmodule

`default_nettype wire

### hdl/dqp_checker.sv
// port-level checker for the parser, bound to the top level
// depends on decimal_to_q16_16_parser_top_macros.svh
`default_nettype none
`include "decimal_to_q16_16_parser_top_macros.svh"

module dqp_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              s_last,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic signed [31:0] m_value
);

    // stalled result word holds
    `DQP_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_value))
    // last character starts the divide, input is held off
    `DQP_ASSERT(a_last_stalls, aclk, aresetn, s_valid && s_ready && s_last |=> !s_ready)
    // no result appears the cycle after the last character
    `DQP_ASSERT(a_no_early_out, aclk, aresetn, s_valid && s_ready && s_last && !m_valid |=> !m_valid)
    // reset leaves the block empty and ready
    `DQP_ASSERT_NR(a_reset_state, aclk, !aresetn |=> !m_valid && s_ready)

endmodule

bind decimal_to_q16_16_parser_top dqp_checker u_dqp_checker (.*);

`default_nettype wire
